>>> sv/fbpa_pkg.sv
package fbpa_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int BLOCK_BYTES_DEF = 1048576;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_GRANTED      = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED    = 3'd1;
    localparam logic [2:0] ST_RELEASED     = 3'd2;
    localparam logic [2:0] ST_FOREIGN      = 3'd3;
    localparam logic [2:0] ST_NULL         = 3'd4;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [31:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] block_addr;
        logic [4:0]  in_use_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_null;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

>>> sv/fbpa_ctrl.sv
module fbpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fbpa_pkg::t_stat i_stat,
    output fbpa_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   done;

    // scan ends on a null free, a hit, or the last slot
    assign done = i_stat.is_null | i_stat.hit | i_stat.last;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!done) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/fbpa_dpath.sv
module fbpa_dpath #(
    parameter int SLOTS       = fbpa_pkg::SLOTS_DEF,
    parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  fbpa_pkg::t_req  i_in_data,
    input  logic            i_out_stall,
    input  fbpa_pkg::t_cmd  i_cmd,
    output fbpa_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output fbpa_pkg::t_rsp  o_out_data
);

    localparam int          IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int          CW        = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [31:0] BLOCK_INC = 32'(BLOCK_BYTES);

    logic [31:0]      r_pool_base;
    logic [SLOTS-1:0] r_flags;
    logic [CW-1:0]    r_count;
    logic             r_req_type;
    logic [31:0]      r_free_addr;
    logic [IW-1:0]    r_idx;
    logic [31:0]      r_run_addr;
    logic             r_out_valid;
    fbpa_pkg::t_rsp   r_out_data;

    logic             cur_flag;
    logic             alloc;

    assign alloc    = (r_req_type == fbpa_pkg::REQ_ALLOC);
    assign cur_flag = r_flags[r_idx];

    assign o_stat.is_null  = !alloc && (r_free_addr == 32'd0);
    assign o_stat.hit      = alloc ? !cur_flag : (r_run_addr == r_free_addr);
    assign o_stat.last     = (r_idx == LAST_IDX);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= 32'd0;
        end else if (i_cfg_we) begin
            r_pool_base <= i_cfg_wdata;
        end
    end

    // request latch and slot walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_type  <= i_in_data.req_type;
            r_free_addr <= i_in_data.free_addr;
            r_idx       <= '0;
            r_run_addr  <= r_pool_base;
        end else if (i_cmd.step) begin
            r_idx      <= r_idx + IW'(1);
            r_run_addr <= r_run_addr + BLOCK_INC;
        end
    end

    // commit flags and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_count <= '0;
        end else if (i_cmd.finish && !o_stat.is_null && o_stat.hit) begin
            if (alloc) begin
                r_flags[r_idx] <= 1'b1;
                r_count        <= r_count + CW'(1);
            end else if (cur_flag) begin
                r_flags[r_idx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data.block_addr   <= 32'd0;
            r_out_data.in_use_count <= 5'(r_count);
            if (o_stat.is_null) begin
                r_out_data.status <= fbpa_pkg::ST_NULL;
            end else if (alloc) begin
                if (o_stat.hit) begin
                    r_out_data.status       <= fbpa_pkg::ST_GRANTED;
                    r_out_data.block_addr   <= r_run_addr;
                    r_out_data.in_use_count <= 5'(r_count + CW'(1));
                end else begin
                    r_out_data.status <= fbpa_pkg::ST_EXHAUSTED;
                end
            end else if (!o_stat.hit) begin
                r_out_data.status <= fbpa_pkg::ST_FOREIGN;
            end else if (cur_flag) begin
                r_out_data.status <= fbpa_pkg::ST_RELEASED;
                if (r_count != '0) begin
                    r_out_data.in_use_count <= 5'(r_count - CW'(1));
                end
            end else begin
                r_out_data.status <= fbpa_pkg::ST_ALREADY_FREE;
            end
        end
    end

endmodule

>>> sv/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator. Hands out blocks of BLOCK_BYTES bytes from
// SLOTS slots starting at the pool_base register, one in-use flag per slot.
// An allocate transaction takes the lowest free slot and returns
// pool_base + slot * BLOCK_BYTES (mod 2^32), or reports the pool exhausted;
// a free transaction releases the lowest slot whose address matches, and
// reports null, foreign or already-free addresses without changing state.
// Every request yields exactly one result transaction carrying the in-use
// count after the request. Requests are served one at a time: the controller
// walks the slots one per cycle through a single address adder and
// comparator, stopping at the first hit, at once on a null free, or at the
// last slot on a miss or an exhausted pool, and the finish is held back
// while an earlier result is still stalled in the output register.
// A result waits in an output register, so the next request is taken and
// scanned while the previous result is still stalled. Write pool_base only
// while no request is in flight.
module fixed_block_pool_allocator #(
    parameter int SLOTS       = fbpa_pkg::SLOTS_DEF,
    parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration: pool_base
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fbpa_pkg::t_req i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fbpa_pkg::t_rsp o_out_data
);

    fbpa_pkg::t_cmd  cmd;
    fbpa_pkg::t_stat stat;
    logic            busy;

    // hold off new requests while a scan is in progress
    assign o_in_stall = busy;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fbpa_dpath #(
        .SLOTS       (SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/fbpa_checker.sv
module fbpa_checker #(
    parameter int SLOTS = fbpa_pkg::SLOTS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input fbpa_pkg::t_rsp o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while scan in progress");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != fbpa_pkg::ST_GRANTED)
        |-> (o_out_data.block_addr == 32'd0))
        else $error("non-grant result carries an address");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= fbpa_pkg::ST_ALREADY_FREE))
        else $error("undefined status code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (SLOTS > 31) || (int'(o_out_data.in_use_count) <= SLOTS))
        else $error("in-use count exceeds slot count");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(.SLOTS(SLOTS)) u_fbpa_checker (.*);

>>> tb/sv/testbench.sv
module testbench;

    localparam int SLOTS        = fbpa_pkg::SLOTS_DEF;
    localparam int BLOCK_BYTES  = fbpa_pkg::BLOCK_BYTES_DEF;
    localparam int PHASE_ITEMS  = 205;
    localparam int CHUNK_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // Clock and synchronous active-low reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // Every DUT input starts at a known value.
    logic           cfg_we     = 1'b0;
    logic [31:0]    cfg_wdata  = '0;
    logic           in_valid   = 1'b0;
    fbpa_pkg::t_req in_data    = '0;
    logic           out_stall  = 1'b0;
    logic           in_stall;
    logic           out_valid;
    fbpa_pkg::t_rsp out_data;

    fixed_block_pool_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Shadow copy of the pool: one busy flag per slot, the busy count and
    // the base address last written to the register.
    logic [SLOTS-1:0] slot_busy  = '0;
    int               busy_count = 0;
    logic [31:0]      pool_base_q = '0;

    // Results still owed by the DUT, oldest first.
    fbpa_pkg::t_rsp pending_rsp[$];

    int  mismatches  = 0;
    int  requests    = 0;
    int  results     = 0;
    int  base_writes = 0;
    int  status_seen[6];
    bit  calm        = 1'b0;
    int  cycles      = 0;

    // Directed table.
    typedef struct {
        fbpa_pkg::t_req rq;
        bit             typed;
        fbpa_pkg::t_rsp want;
    } t_row;

    t_row plan[$];

    function automatic logic [31:0] slot_addr(input int s);
        return pool_base_q + 32'(s) * 32'(BLOCK_BYTES);
    endfunction

    // Serve one request against the shadow pool and return its result.
    // Allocate takes the lowest free slot; free matches the lowest slot whose
    // wrapped address equals the request address.
    function automatic fbpa_pkg::t_rsp pool_serve(input fbpa_pkg::t_req rq);
        fbpa_pkg::t_rsp rs;
        bit             done;
        done          = 1'b0;
        rs.block_addr = '0;
        if (rq.req_type == fbpa_pkg::REQ_ALLOC) begin
            rs.status = fbpa_pkg::ST_EXHAUSTED;
            for (int s = 0; s < SLOTS; s++) begin
                if (!done && !slot_busy[s]) begin
                    slot_busy[s]  = 1'b1;
                    busy_count++;
                    rs.block_addr = slot_addr(s);
                    rs.status     = fbpa_pkg::ST_GRANTED;
                    done          = 1'b1;
                end
            end
        end else if (rq.free_addr == '0) begin
            // Null stays ignored even where a slot sits at address zero.
            rs.status = fbpa_pkg::ST_NULL;
        end else begin
            rs.status = fbpa_pkg::ST_FOREIGN;
            for (int s = 0; s < SLOTS; s++) begin
                if (!done && slot_addr(s) == rq.free_addr) begin
                    if (slot_busy[s]) begin
                        slot_busy[s] = 1'b0;
                        if (busy_count > 0) busy_count--;
                        rs.status = fbpa_pkg::ST_RELEASED;
                    end else begin
                        // Double free: leave flag and count alone.
                        rs.status = fbpa_pkg::ST_ALREADY_FREE;
                    end
                    done = 1'b1;
                end
            end
        end
        rs.in_use_count = 5'(busy_count);
        return rs;
    endfunction

    task automatic add_row(input logic rt, input logic [31:0] fa, input bit typed,
                           input logic [2:0] st, input logic [31:0] ba,
                           input logic [4:0] cnt);
        t_row r;
        r.rq.req_type        = rt;
        r.rq.free_addr       = fa;
        r.typed              = typed;
        r.want.status        = st;
        r.want.block_addr    = ba;
        r.want.in_use_count  = cnt;
        plan.push_back(r);
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)   return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Build a random request. Most frees hit a slot address of the current
    // base so the pool both fills and drains; the rest are null, near misses
    // and fully random addresses.
    function automatic fbpa_pkg::t_req make_request(input int alloc_pct);
        fbpa_pkg::t_req rq;
        int             k;
        rq.free_addr = $urandom;
        if ($urandom_range(0, 99) < alloc_pct) begin
            rq.req_type = fbpa_pkg::REQ_ALLOC;
        end else begin
            rq.req_type = fbpa_pkg::REQ_FREE;
            k = $urandom_range(0, 99);
            if (k < 60)
                rq.free_addr = slot_addr($urandom_range(0, SLOTS - 1));
            else if (k < 70)
                rq.free_addr = '0;
            else if (k < 82)
                rq.free_addr = slot_addr($urandom_range(0, SLOTS - 1))
                             + 32'($urandom_range(1, BLOCK_BYTES - 1));
        end
        return rq;
    endfunction

    // Hold the transaction until the DUT takes it, then log what it owes.
    task automatic send_req(input fbpa_pkg::t_req rq, input bit typed,
                            input fbpa_pkg::t_rsp want);
        fbpa_pkg::t_rsp pred;
        in_valid <= 1'b1;
        in_data  <= rq;
        do @(posedge i_clk); while (in_stall);
        pred = pool_serve(rq);
        pending_rsp.push_back(typed ? want : pred);
        requests++;
    endtask

    // Drop valid for a random number of cycles after an accepted transaction.
    task automatic idle_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Let every owed result come back before the register may change.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] b);
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        @(posedge i_clk);
        pool_base_q = b;
        base_writes++;
        cfg_we    <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                     results, what, want, got);
    endtask

    // Result stall generator: random runs of stall, no new run while calm.
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall  <= 1'b0;
            stall_left <= gap_len();
        end
    end

    // Check each accepted result against the oldest owed one, field by field.
    always @(posedge i_clk) begin : check_rsp
        fbpa_pkg::t_rsp want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_rsp.size() == 0) begin
                note_mismatch("unexpected result", '0, out_data.block_addr);
            end else begin
                want = pending_rsp.pop_front();
                if (out_data.status != want.status)
                    note_mismatch("status", 32'(want.status), 32'(out_data.status));
                if (out_data.block_addr != want.block_addr)
                    note_mismatch("block_addr", want.block_addr, out_data.block_addr);
                if (out_data.in_use_count != want.in_use_count)
                    note_mismatch("in_use_count", 32'(want.in_use_count),
                                  32'(out_data.in_use_count));
            end
            if (out_data.status <= fbpa_pkg::ST_ALREADY_FREE)
                status_seen[out_data.status]++;
            results++;
        end
    end

    // Watchdog: end a hung run.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycles, pending_rsp.size());
        $display("fixed_block_pool_allocator verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]    bases[$];
        int             alloc_pct;
        fbpa_pkg::t_rsp none;

        none = '0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // Directed rows, base 0 from reset. Null, double free and foreign
        // checks on the empty pool first.
        add_row(fbpa_pkg::REQ_FREE, 32'h0000_0000, 1, fbpa_pkg::ST_NULL, '0, 5'd0);
        add_row(fbpa_pkg::REQ_FREE, 32'h0010_0000, 1, fbpa_pkg::ST_ALREADY_FREE,
                '0, 5'd0);
        add_row(fbpa_pkg::REQ_FREE, 32'hFFFF_FFFF, 1, fbpa_pkg::ST_FOREIGN, '0, 5'd0);
        add_row(fbpa_pkg::REQ_FREE, 32'h0010_0001, 1, fbpa_pkg::ST_FOREIGN, '0, 5'd0);
        // Fill the pool slot by slot, then overflow it.
        for (int s = 0; s < SLOTS; s++)
            add_row(fbpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 1, fbpa_pkg::ST_GRANTED,
                    32'(s) * 32'(BLOCK_BYTES), 5'(s + 1));
        add_row(fbpa_pkg::REQ_ALLOC, '0, 1, fbpa_pkg::ST_EXHAUSTED, '0, 5'(SLOTS));
        // Release the top slot, free it twice, take it back.
        add_row(fbpa_pkg::REQ_FREE, 32'(SLOTS - 1) * 32'(BLOCK_BYTES), 1,
                fbpa_pkg::ST_RELEASED, '0, 5'(SLOTS - 1));
        add_row(fbpa_pkg::REQ_FREE, 32'(SLOTS - 1) * 32'(BLOCK_BYTES), 1,
                fbpa_pkg::ST_ALREADY_FREE, '0, 5'(SLOTS - 1));
        add_row(fbpa_pkg::REQ_ALLOC, '0, 0, fbpa_pkg::ST_GRANTED, '0, '0);
        // Slot 0 lies at address zero here, so this free is ignored.
        add_row(fbpa_pkg::REQ_FREE, 32'h0000_0000, 1, fbpa_pkg::ST_NULL, '0,
                5'(SLOTS));

        // Base settings for the random phases: wrap extremes, slot one at
        // address zero, zero itself, mid range and random picks.
        bases = '{32'hFFFF_FFFF, 32'hFFF0_0000, 32'h0000_0000, 32'h8000_0000,
                  32'h0000_0001};
        repeat (3) bases.push_back($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            send_req(plan[i].rq, plan[i].typed, plan[i].want);
            idle_gap();
        end

        foreach (bases[p]) begin
            drain();
            write_base(bases[p]);
            alloc_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Swing the mix so the pool runs both full and empty.
                if (n % CHUNK_ITEMS == 0) begin
                    case ($urandom_range(0, 2))
                        0:       alloc_pct = 15;
                        1:       alloc_pct = 50;
                        default: alloc_pct = 85;
                    endcase
                    calm <= ($urandom_range(0, 4) == 0);
                end
                send_req(make_request(alloc_pct), 1'b0, none);
                idle_gap();
            end
        end

        // Wait out every owed result, then give stragglers time to show up.
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests under %0d pool_base writes, %0d results checked",
                 requests, base_writes, results);
        $display("granted %0d, exhausted %0d, released %0d, foreign %0d,",
                 status_seen[fbpa_pkg::ST_GRANTED], status_seen[fbpa_pkg::ST_EXHAUSTED],
                 status_seen[fbpa_pkg::ST_RELEASED], status_seen[fbpa_pkg::ST_FOREIGN]);
        $display("null %0d, double free %0d",
                 status_seen[fbpa_pkg::ST_NULL], status_seen[fbpa_pkg::ST_ALREADY_FREE]);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("fixed_block_pool_allocator verification clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, pending_rsp.size());
            $display("fixed_block_pool_allocator verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/fbpa_pkg.sv
sv/fbpa_ctrl.sv
sv/fbpa_dpath.sv
sv/fixed_block_pool_allocator.sv
sv/fbpa_checker.sv
tb/sv/testbench.sv
